### rtl/cskdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskdr_pkg: shared types and constants for the clock time-set key block
// Beat payloads, configuration bundle, register indexes and time limits.
// ----------------------------------------------------------------------------
package cskdr_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_COUNT_CAP       = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_MIN    = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PRESS      = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_INTERVAL = 4'd3;

   // register reset values
   localparam logic [7:0] COUNT_CAP_RST       = 8'hf0;
   localparam logic [7:0] DEBOUNCE_MIN_RST    = 8'd5;
   localparam logic [7:0] LONG_PRESS_RST      = 8'd100;
   localparam logic [7:0] REPEAT_INTERVAL_RST = 8'd50;

   // time limits
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [5:0] HOUR_LAST   = 6'd23;

   // item kinds
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_CHECK = 1'b1;

   typedef struct packed {
      logic       func;
      logic       minus_key_n;
      logic       plus_key_n;
      logic [5:0] cur_minute;
      logic [4:0] cur_hour;
   } req_type;

   typedef struct packed {
      logic [5:0] new_minute;
      logic [4:0] new_hour;
      logic       time_changed;
   } rsp_type;

   typedef struct packed {
      logic [7:0] count_cap;
      logic [7:0] debounce_min;
      logic [7:0] long_press;
      logic [7:0] repeat_interval;
   } cfg_type;

endpackage

### rtl/cskdr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskdr_csr: configuration registers
// Four 8-bit registers written through a plain write port.
// ----------------------------------------------------------------------------
module cskdr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cskdr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [cskdr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output cskdr_pkg::cfg_type                  cfg
);
   import cskdr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_COUNT_CAP:       cfg_in.count_cap       = csr_wdata;
            CSR_DEBOUNCE_MIN:    cfg_in.debounce_min    = csr_wdata;
            CSR_LONG_PRESS:      cfg_in.long_press      = csr_wdata;
            CSR_REPEAT_INTERVAL: cfg_in.repeat_interval = csr_wdata;
            default:             cfg_in = cfg_ff;   // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_cap       <= COUNT_CAP_RST;
         cfg_ff.debounce_min    <= DEBOUNCE_MIN_RST;
         cfg_ff.long_press      <= LONG_PRESS_RST;
         cfg_ff.repeat_interval <= REPEAT_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/cskdr_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskdr_adjust: key hold counters and time adjust logic
// Holds the per-key counters, heartbeat and last change tick; computes the
// result for one item and updates state when the item is processed.
// ----------------------------------------------------------------------------
module cskdr_adjust (
   input  logic                 clock,
   input  logic                 reset,
   input  cskdr_pkg::cfg_type   cfg,
   input  logic                 fire,
   input  cskdr_pkg::req_type   req,
   output cskdr_pkg::rsp_type   rsp
);
   import cskdr_pkg::*;

   logic [7:0] minus_cnt_ff, minus_cnt_in;
   logic [7:0] plus_cnt_ff,  plus_cnt_in;
   logic [7:0] heartbeat_ff, heartbeat_in;
   logic [7:0] last_chg_ff,  last_chg_in;

   logic       wait_gap;
   logic       do_plus, do_minus;
   logic [5:0] min_p, min_m;
   logic [5:0] hour_p, hour_m;
   logic [5:0] hour_inc;
   logic [7:0] gap;

   assign gap      = heartbeat_ff - last_chg_ff;
   assign wait_gap = (plus_cnt_ff < cfg.long_press) && (minus_cnt_ff < cfg.long_press) &&
                     (gap < cfg.repeat_interval);
   assign do_plus  = !wait_gap && (plus_cnt_ff  > cfg.debounce_min);
   assign do_minus = !wait_gap && (minus_cnt_ff > cfg.debounce_min);
   assign hour_inc = {1'b0, req.cur_hour} + 6'd1;

   always_comb begin
      // plus step
      min_p  = req.cur_minute;
      hour_p = {1'b0, req.cur_hour};
      if (do_plus) begin
         if (req.cur_minute >= MINUTE_LAST) begin
            min_p  = '0;
            hour_p = (hour_inc > HOUR_LAST) ? '0 : hour_inc;
         end else begin
            min_p = req.cur_minute + 6'd1;
         end
      end
      // minus step on top of plus result
      min_m  = min_p;
      hour_m = hour_p;
      if (do_minus) begin
         if (min_p == '0) begin
            min_m  = MINUTE_LAST;
            hour_m = (hour_p == '0 || hour_p > HOUR_LAST) ? HOUR_LAST : hour_p - 6'd1;
         end else if (min_p > MINUTE_LAST) begin
            min_m = MINUTE_LAST;
         end else begin
            min_m = min_p - 6'd1;
         end
      end
   end

   always_comb begin
      minus_cnt_in = minus_cnt_ff;
      plus_cnt_in  = plus_cnt_ff;
      heartbeat_in = heartbeat_ff;
      last_chg_in  = last_chg_ff;
      if (fire) begin
         if (req.func == FUNC_TICK) begin
            if (req.minus_key_n)                     minus_cnt_in = '0;
            else if (minus_cnt_ff < cfg.count_cap)   minus_cnt_in = minus_cnt_ff + 8'd1;
            if (req.plus_key_n)                      plus_cnt_in = '0;
            else if (plus_cnt_ff < cfg.count_cap)    plus_cnt_in = plus_cnt_ff + 8'd1;
            heartbeat_in = heartbeat_ff + 8'd1;
         end else if (do_plus || do_minus) begin
            last_chg_in = heartbeat_ff;
         end
      end
   end

   always_comb begin
      if (req.func == FUNC_CHECK) begin
         rsp.new_minute   = min_m;
         rsp.new_hour     = hour_m[4:0];
         rsp.time_changed = do_plus || do_minus;
      end else begin
         rsp.new_minute   = req.cur_minute;
         rsp.new_hour     = req.cur_hour;
         rsp.time_changed = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minus_cnt_ff <= '0;
         plus_cnt_ff  <= '0;
         heartbeat_ff <= '0;
         last_chg_ff  <= '0;
      end else begin
         minus_cnt_ff <= minus_cnt_in;
         plus_cnt_ff  <= plus_cnt_in;
         heartbeat_ff <= heartbeat_in;
         last_chg_ff  <= last_chg_in;
      end
   end

endmodule

### rtl/clock_set_key_debounce_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_set_key_debounce_repeat: debounced plus/minus time-set keys
// Tick beats sample two active-low keys; check beats adjust minute/hour with
// debounce and auto-repeat, flagging when the time was changed.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input beats (req_data.func: tick or check). A tick updates the
//            key hold counters and heartbeat; a check may step the time.
//   rsp_*  : one result beat per request beat, in order.
//   csr_*  : write-only config (count cap, debounce min, long press, repeat
//            interval); write only while the block is idle.
// Path: an accepted request passes the input register, then the result
//   register. Throughput: one beat per cycle while rsp_ready is high;
//   the adjust logic is a single short pass.
// Stall: when rsp_ready is low the result register holds its beat; the input
//   register still fills, and req_ready drops only once both are occupied.
// Reset (synchronous, active high): pipeline empty, hold counters, heartbeat
//   and last change tick cleared, config back to 240/5/100/50.
// ----------------------------------------------------------------------------
module clock_set_key_debounce_repeat (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cskdr_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cskdr_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [cskdr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [cskdr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cskdr_pkg::*;

   cfg_type cfg;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_next;

   logic advance;   // stage 1 beat moves into the result register
   logic req_fire;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance  || (rsp_valid_ff && !rsp_ready);

   cskdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state only moves when the stage 1 beat is actually consumed
   cskdr_adjust u_adjust (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (advance),
      .req   (s1_data_ff),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/cskdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskdr_checker: port-level assertions for the time-set key block
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module cskdr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input cskdr_pkg::rsp_type   rsp_data
);
   import cskdr_pkg::*;

   // stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an adjusted time always lands on a legal minute
   a_minute_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.time_changed |-> rsp_data.new_minute <= MINUTE_LAST)
      else $error("adjusted minute out of range");

   // a beat accepted just as reset is released finds no result present
   a_ready_gate: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && $past(reset) |-> !rsp_valid)
      else $error("result present while pipeline should be empty");

endmodule

bind clock_set_key_debounce_repeat cskdr_checker u_cskdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/clock_set_key_debounce_repeat_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_set_key_debounce_repeat_tb: self-checking bench for the time-set keys
// Drives tick and check beats through the valid/ready request channel, keeps
// its own copy of the hold counters, heartbeat and repeat spacing, and checks
// every result beat field by field, in order, across several register
// settings and idle patterns.
// ----------------------------------------------------------------------------
module clock_set_key_debounce_repeat_tb;
   import cskdr_pkg::*;

   // cycles with work outstanding but no handshake on either channel
   localparam int unsigned STALL_LIMIT = 1000;
   // request beats per random phase (the long saturating hold may overshoot)
   localparam int PHASE_BEATS = 120;
   localparam int NUM_PHASES  = 8;
   // mismatch lines printed before going quiet (all are still counted)
   localparam int PRINT_LIMIT = 100;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // beats waiting for the driver, and the results they are expected to give
   req_type pending_beats[$];
   rsp_type expected_times[$];

   // predictor copy of the block: registers plus the four state bytes
   cfg_type    key_cfg;
   logic [7:0] plus_hold        = '0;
   logic [7:0] minus_hold       = '0;
   logic [7:0] tick_count       = '0;
   logic [7:0] last_adjust_tick = '0;

   int          mismatch_count = 0;
   int          phase_beats    = 0;
   int          sender_idle_pct = 0;
   int          rsp_stall_pct   = 0;
   logic        req_taken      = 1'b0;
   int unsigned stall_cycles   = 0;

   clock_set_key_debounce_repeat u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // hold counter: clears on release, counts while held, sticks at the cap
   function automatic logic [7:0] next_hold(logic [7:0] count, logic key_n);
      if (key_n)
         return 8'd0;
      if (count < key_cfg.count_cap)
         return count + 8'd1;
      return count;
   endfunction

   // Advances the predictor by one beat and returns the result it must give.
   function automatic rsp_type predict_time_set(req_type beat);
      rsp_type    r;
      int         minute;
      int         hour;
      logic       hold_off;
      logic       adjusted;
      logic [7:0] since;
      minute   = beat.cur_minute;
      hour     = beat.cur_hour;
      adjusted = 1'b0;
      since    = tick_count - last_adjust_tick;   // wraps mod 256
      if (beat.func == FUNC_TICK) begin
         minus_hold = next_hold(minus_hold, beat.minus_key_n);
         plus_hold  = next_hold(plus_hold, beat.plus_key_n);
         tick_count = tick_count + 8'd1;
      end else begin
         // short presses are rate limited; a long press on either key is not
         hold_off = (plus_hold < key_cfg.long_press) &&
                    (minus_hold < key_cfg.long_press) &&
                    (since < key_cfg.repeat_interval);
         if (!hold_off) begin
            // plus first, then minus works on what plus left
            if (plus_hold > key_cfg.debounce_min) begin
               adjusted = 1'b1;
               if (minute >= MINUTE_LAST) begin
                  minute = 0;
                  hour   = hour + 1;
                  if (hour > HOUR_LAST)
                     hour = 0;
               end else begin
                  minute = minute + 1;
               end
            end
            if (minus_hold > key_cfg.debounce_min) begin
               adjusted = 1'b1;
               if (minute == 0) begin
                  minute = MINUTE_LAST;
                  if (hour == 0 || hour > HOUR_LAST)
                     hour = HOUR_LAST;
                  else
                     hour = hour - 1;
               end else if (minute > MINUTE_LAST) begin
                  minute = MINUTE_LAST;   // out-of-range minute clamps, no borrow
               end else begin
                  minute = minute - 1;
               end
            end
            if (adjusted)
               last_adjust_tick = tick_count;
         end
      end
      r.new_minute   = 6'(minute);
      r.new_hour     = 5'(hour);
      r.time_changed = adjusted;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: new beat at the falling edge once the old one is taken.
   // Valid is computed once per edge, so it is never dropped and re-raised
   // within one step.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin : drive_rsp_ready
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge. Results are checked
   // before the new request is predicted; as each beat passes the input and
   // result registers first, a result never belongs to a beat taken at the
   // same edge anyway. Also hosts the watchdog so it sees the queues after
   // this edge's updates.
   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    req_fire;
      logic    rsp_fire;
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         if (rsp_fire) begin
            if (expected_times.size() == 0) begin
               report_mismatch($sformatf("result beat %0d:%0d chg=%0b with none expected",
                                         rsp_data.new_hour, rsp_data.new_minute,
                                         rsp_data.time_changed));
            end else begin
               want = expected_times.pop_front();
               if (rsp_data.new_minute !== want.new_minute)
                  report_mismatch($sformatf("new_minute got %0d want %0d",
                                            rsp_data.new_minute, want.new_minute));
               if (rsp_data.new_hour !== want.new_hour)
                  report_mismatch($sformatf("new_hour got %0d want %0d",
                                            rsp_data.new_hour, want.new_hour));
               if (rsp_data.time_changed !== want.time_changed)
                  report_mismatch($sformatf("time_changed got %b want %b",
                                            rsp_data.time_changed, want.time_changed));
            end
         end
         if (req_fire)
            expected_times.push_back(predict_time_set(req_data));
         req_taken <= req_fire;

         // watchdog: only counts while something is still owed
         if (req_fire || rsp_fire ||
             (pending_beats.size() == 0 && !req_valid && expected_times.size() == 0)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("clock_set_key_debounce_repeat regression: fail");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic push_beat(logic func, logic minus_n, logic plus_n,
                            logic [5:0] minute, logic [4:0] hour);
      req_type b;
      b.func        = func;
      b.minus_key_n = minus_n;
      b.plus_key_n  = plus_n;
      b.cur_minute  = minute;
      b.cur_hour    = hour;
      pending_beats.push_back(b);
      phase_beats++;
   endtask

   // mostly legal times, with the wrap points and the out-of-range codes
   function automatic logic [5:0] pick_minute();
      case ($urandom_range(9))
         0:       return 6'd0;
         1:       return MINUTE_LAST;
         2:       return 6'($urandom_range(60, 63));
         default: return 6'($urandom_range(59));
      endcase
   endfunction

   function automatic logic [4:0] pick_hour();
      case ($urandom_range(9))
         0:       return 5'd0;
         1:       return 5'(HOUR_LAST);
         2:       return 5'($urandom_range(24, 31));
         default: return 5'($urandom_range(23));
      endcase
   endfunction

   // Keys held at fixed levels for n_ticks ticks, with occasional contact
   // bounce, and on average check_pct/(100-check_pct) checks after each tick.
   task automatic hold_session(int n_ticks, logic plus_n, logic minus_n, int check_pct);
      logic p;
      logic m;
      repeat (n_ticks) begin
         p = plus_n;
         m = minus_n;
         if ($urandom_range(99) < 4)
            p = ~p;
         if ($urandom_range(99) < 4)
            m = ~m;
         push_beat(FUNC_TICK, m, p, pick_minute(), pick_hour());
         while ($urandom_range(99) < check_pct)
            push_beat(FUNC_CHECK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      pick_minute(), pick_hour());
      end
   endtask

   task automatic random_session();
      int len;
      len = $urandom_range(1, 40);
      case ($urandom_range(9))
         0, 1, 2, 3: hold_session(len, 1'b0, 1'b1, 45);     // plus held
         4, 5, 6:    hold_session(len, 1'b1, 1'b0, 45);     // minus held
         7:          hold_session(len, 1'b0, 1'b0, 45);     // both held
         8:          hold_session(len / 4 + 1, 1'b1, 1'b1, 30); // released
         default: begin
            // noise: anything goes
            repeat ($urandom_range(1, 8))
               push_beat($urandom_range(1) ? FUNC_CHECK : FUNC_TICK,
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         6'($urandom_range(63)), 5'($urandom_range(31)));
         end
      endcase
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_COUNT_CAP:       key_cfg.count_cap       = data;
         CSR_DEBOUNCE_MIN:    key_cfg.debounce_min    = data;
         CSR_LONG_PRESS:      key_cfg.long_press      = data;
         CSR_REPEAT_INTERVAL: key_cfg.repeat_interval = data;
         default: ;   // unmapped index: ignored by the block
      endcase
   endtask

   // all four registers plus one write to an unmapped index; ends just past
   // a rising edge so queue pushes never share a step with the driver
   task automatic program_cfg(logic [7:0] cap, logic [7:0] deb, logic [7:0] lp,
                              logic [7:0] intv);
      write_csr(CSR_COUNT_CAP, cap);
      write_csr(CSR_DEBOUNCE_MIN, deb);
      write_csr(CSR_LONG_PRESS, lp);
      write_csr(CSR_REPEAT_INTERVAL, intv);
      write_csr(CSR_ADDR_W'($urandom_range(4, 15)), CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      #1;
   endtask

   // every beat sent and every result back, then let the pipe settle
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_beats.size() != 0 || req_valid || expected_times.size() != 0);
      repeat (3) @(posedge clock);
      #1;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic sat_plus_n;
      logic sat_minus_n;
      key_cfg = '{COUNT_CAP_RST, DEBOUNCE_MIN_RST, LONG_PRESS_RST, REPEAT_INTERVAL_RST};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed: one tick makes a press, no repeat spacing, so each check
      // hits the adjust path straight away.
      program_cfg(8'd255, 8'd0, 8'd0, 8'd0);
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd63, 5'd31);     // no key: out-of-range passes
      push_beat(FUNC_TICK,  1'b1, 1'b0, 6'd0, 5'd0);       // plus down
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd59, 5'd23);     // midnight rollover
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd59, 5'd31);     // bad hour carries to 0
      push_beat(FUNC_CHECK, 1'b0, 1'b0, 6'd63, 5'd5);      // bad minute rolls over
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd10, 5'd10);
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd0, 5'd0);
      push_beat(FUNC_TICK,  1'b0, 1'b1, 6'd0, 5'd0);       // minus down, plus up
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd0, 5'd0);       // borrow to 23:59
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd0, 5'd31);      // bad hour on borrow
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd0, 5'd5);
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd62, 5'd7);      // clamps to 59, no borrow
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd30, 5'd12);
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd59, 5'd23);
      push_beat(FUNC_TICK,  1'b0, 1'b0, 6'd63, 5'd31);     // both down
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd59, 5'd23);     // plus then minus
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd20, 5'd3);
      push_beat(FUNC_TICK,  1'b1, 1'b1, 6'd0, 5'd0);       // both released
      push_beat(FUNC_CHECK, 1'b1, 1'b1, 6'd45, 5'd10);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: program_cfg(COUNT_CAP_RST, DEBOUNCE_MIN_RST, LONG_PRESS_RST,
                           REPEAT_INTERVAL_RST);
            1: program_cfg(8'd0, 8'd0, 8'd0, 8'd0);
            2: program_cfg(8'd255, 8'd255, 8'd255, 8'd255);
            3: program_cfg(8'd30, 8'd3, 8'd20, 8'd6);
            4: program_cfg(8'd255, 8'd0, 8'd255, 8'd255);
            5: program_cfg(8'd10, 8'd1, 8'd8, 8'd2);
            default: program_cfg(8'($urandom_range(8, 60)), 8'($urandom_range(0, 6)),
                                 8'($urandom_range(0, 40)), 8'($urandom_range(0, 12)));
         endcase

         // rotate: free running, sender gaps, result stalls, light mix
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 56; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin sender_idle_pct = 7; rsp_stall_pct = 7; end
         endcase

         phase_beats = 0;
         // hold past the cap so the counter saturates and long press kicks in
         case ($urandom_range(2))
            0:       begin sat_plus_n = 1'b0; sat_minus_n = 1'b1; end
            1:       begin sat_plus_n = 1'b1; sat_minus_n = 1'b0; end
            default: begin sat_plus_n = 1'b0; sat_minus_n = 1'b0; end
         endcase
         hold_session(key_cfg.count_cap + $urandom_range(2, 6), sat_plus_n, sat_minus_n, 8);

         // sender holds off until the block has answered everything
         wait_drained();

         while (phase_beats < PHASE_BEATS)
            random_session();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("clock_set_key_debounce_repeat regression: pass");
      else
         $display("clock_set_key_debounce_repeat regression: fail");
      $finish;
   end

endmodule
